/* rtl/rcm_pkg.sv */
// rcm_pkg: shared constants, codes and control types of the rms current meter
// used by rcm_ctrl, rcm_dp and rms_current_meter; no dependencies
`default_nettype none

package rcm_pkg;

	// default widths, used as defaults of the top level parameters
	localparam int ADC_BITS_DEF   = 10;
	localparam int COUNT_BITS_DEF = 14;

	// fixed widths of the accumulator and the result path
	localparam int SUM_BITS    = 40;
	localparam int ROOT_BITS   = SUM_BITS / 2;
	localparam int SCALE_BITS  = 8;
	localparam int RESULT_BITS = 16;

	localparam logic [SCALE_BITS-1:0]  SCALE_RESET = 8'd49;
	localparam logic [RESULT_BITS-1:0] RESULT_MAX  = 16'hFFFF;

	// iteration counts of the divider and the square root unit
	localparam int DIV_STEPS  = SUM_BITS;
	localparam int SQRT_STEPS = ROOT_BITS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS);

	// operation codes of an input word
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_CALIB   = 1'b1;

	// result kinds
	localparam logic KIND_CURRENT = 1'b0;
	localparam logic KIND_ZERO    = 1'b1;

	typedef logic [STEP_BITS-1:0] step_t;

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_PIPE1,
		ST_PIPE2,
		ST_DIV_LOAD,
		ST_DIV,
		ST_SQRT_LOAD,
		ST_SQRT,
		ST_SCALE,
		ST_FINISH
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic div_load;
		logic div_step;
		logic sqrt_load;
		logic sqrt_step;
		logic scale;
		logic finish;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic calib;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/rms_current_meter.sv */
// rms_current_meter: samples are taken one per cycle while a window is open
// a window end yields its result word, and input is held off until then: pipeline drain states,
// a divider load and the serial divider, for measurement a root load, the serial square root
// and a multiply state, then a load into the result register; a result word still stalled
// extends the hold-off
// arst_n clears control state, scale to 49 and zero level to mid scale; no sweep
`default_nettype none

module rms_current_meter #(
	parameter int ADC_BITS   = rcm_pkg::ADC_BITS_DEF,
	parameter int COUNT_BITS = rcm_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// sample words
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             operation,
	input  wire logic [ADC_BITS-1:0]              adc_sample,
	input  wire logic                             window_last,
	// result words
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  result_kind,
	output logic [rcm_pkg::RESULT_BITS-1:0]       result_value,
	// scale register write
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rcm_pkg::SCALE_BITS-1:0]   cfg_data
);

	rcm_pkg::cmd_t cmd;
	rcm_pkg::sts_t sts;
	logic          cfg_write;

	// the scale register takes a word in any cycle
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// sequencer: accumulate, drain pipeline, divide, for measurement root and scale, load result
	rcm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.window_last (window_last),
		.in_stall    (in_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	// accumulator of squared deviations or raw samples, serial divider and square root, result register
	rcm_dp #(
		.ADC_BITS   (ADC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.adc_sample   (adc_sample),
		.window_last  (window_last),
		.cfg_valid    (cfg_write),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.result_value (result_value)
	);

endmodule

`default_nettype wire

/* rtl/rcm_ctrl.sv */
// rcm_ctrl: sequencing state machine of the rms current meter
// depends on rcm_pkg (state type, command and status structs, step counts)
`default_nettype none

module rcm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          window_last,
	output logic               in_stall,
	input  rcm_pkg::sts_t      sts,
	output rcm_pkg::cmd_t      cmd
);

	rcm_pkg::state_t state_q;
	rcm_pkg::state_t state_d;
	rcm_pkg::step_t  step_q;
	logic            accept;

	assign in_stall = (state_q != rcm_pkg::ST_ACCUM);
	assign accept   = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcm_pkg::ST_ACCUM: begin
				if (accept && window_last) state_d = rcm_pkg::ST_PIPE1;
			end
			rcm_pkg::ST_PIPE1:     state_d = rcm_pkg::ST_PIPE2;
			rcm_pkg::ST_PIPE2:     state_d = rcm_pkg::ST_DIV_LOAD;
			rcm_pkg::ST_DIV_LOAD:  state_d = rcm_pkg::ST_DIV;
			rcm_pkg::ST_DIV: begin
				if (step_q == rcm_pkg::STEP_BITS'(rcm_pkg::DIV_STEPS - 1)) begin
					if (sts.calib) state_d = rcm_pkg::ST_FINISH;
					else           state_d = rcm_pkg::ST_SQRT_LOAD;
				end
			end
			rcm_pkg::ST_SQRT_LOAD: state_d = rcm_pkg::ST_SQRT;
			rcm_pkg::ST_SQRT: begin
				if (step_q == rcm_pkg::STEP_BITS'(rcm_pkg::SQRT_STEPS - 1))
					state_d = rcm_pkg::ST_SCALE;
			end
			rcm_pkg::ST_SCALE:     state_d = rcm_pkg::ST_FINISH;
			rcm_pkg::ST_FINISH: begin
				if (sts.out_free) state_d = rcm_pkg::ST_ACCUM;
			end
			default:               state_d = rcm_pkg::ST_ACCUM;
		endcase
	end

	// outputs
	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.div_load  = (state_q == rcm_pkg::ST_DIV_LOAD);
		cmd.div_step  = (state_q == rcm_pkg::ST_DIV);
		cmd.sqrt_load = (state_q == rcm_pkg::ST_SQRT_LOAD);
		cmd.sqrt_step = (state_q == rcm_pkg::ST_SQRT);
		cmd.scale     = (state_q == rcm_pkg::ST_SCALE);
		cmd.finish    = (state_q == rcm_pkg::ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcm_pkg::ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rcm_pkg::ST_DIV || state_q == rcm_pkg::ST_SQRT)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

endmodule

`default_nettype wire

/* rtl/rcm_dp.sv */
// rcm_dp: accumulation pipeline, serial divider, serial square root, scaling
// and result register of the rms current meter; depends on rcm_pkg
`default_nettype none

module rcm_dp #(
	parameter int ADC_BITS   = rcm_pkg::ADC_BITS_DEF,
	parameter int COUNT_BITS = rcm_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  rcm_pkg::cmd_t                         cmd,
	output rcm_pkg::sts_t                         sts,
	input  wire logic                             operation,
	input  wire logic [ADC_BITS-1:0]              adc_sample,
	input  wire logic                             window_last,
	input  wire logic                             cfg_valid,
	input  wire logic [rcm_pkg::SCALE_BITS-1:0]   cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  result_kind,
	output logic [rcm_pkg::RESULT_BITS-1:0]       result_value
);

	localparam int SQ_BITS   = 2 * ADC_BITS;
	localparam int SUM_BITS  = rcm_pkg::SUM_BITS;
	localparam int ROOT_BITS = rcm_pkg::ROOT_BITS;
	localparam int PROD_BITS = ROOT_BITS + rcm_pkg::SCALE_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [ADC_BITS-1:0]   ADC_MAX   = {ADC_BITS{1'b1}};
	localparam logic [ADC_BITS-1:0]   ZERO_RST  = {1'b1, {(ADC_BITS-1){1'b0}}};
	localparam logic [SUM_BITS-1:0]   BIT_TOP   = {2'b01, {(SUM_BITS-2){1'b0}}};

	logic [rcm_pkg::SCALE_BITS-1:0] scale_q;
	logic [ADC_BITS-1:0]            zero_q;
	logic [COUNT_BITS-1:0]          count_q;
	logic [SUM_BITS-1:0]            sum_q;
	logic                           last_op_q;

	logic                valid_s1;
	logic                op_s1;
	logic [ADC_BITS-1:0] sample_s1;
	logic                valid_s2;
	logic [SQ_BITS-1:0]  add_s2;

	logic [ADC_BITS-1:0] diff;
	logic [SQ_BITS-1:0]  square;
	logic [SUM_BITS:0]   sum_ext;

	logic [SUM_BITS-1:0]   num_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   trial_sub;
	logic                  q_bit;

	logic [SUM_BITS-1:0] v_q;
	logic [SUM_BITS-1:0] root_q;
	logic [SUM_BITS-1:0] bit_q;
	logic [SUM_BITS-1:0] root_try;

	logic [PROD_BITS-1:0]            prod_q;
	logic [ADC_BITS-1:0]             mean_sat;
	logic [rcm_pkg::RESULT_BITS-1:0] cur_sat;

	logic                            out_valid_q;
	logic                            out_kind_q;
	logic [rcm_pkg::RESULT_BITS-1:0] out_value_q;

	// squared distance from the zero level
	always_comb begin
		if (sample_s1 >= zero_q) diff = sample_s1 - zero_q;
		else                     diff = zero_q - sample_s1;
		square  = SQ_BITS'(diff) * SQ_BITS'(diff);
		sum_ext = {1'b0, sum_q} + (SUM_BITS + 1)'(add_s2);
	end

	// restoring divider, one quotient bit per step
	always_comb begin
		trial     = {rem_q, num_q[SUM_BITS-1]};
		trial_sub = trial - {1'b0, count_q};
		q_bit     = (trial >= {1'b0, count_q}) && (count_q != '0);
	end

	assign root_try = root_q + bit_q;

	// final saturation of both result kinds
	always_comb begin
		if (num_q > SUM_BITS'(ADC_MAX)) mean_sat = ADC_MAX;
		else                            mean_sat = num_q[ADC_BITS-1:0];
		if (prod_q > PROD_BITS'(rcm_pkg::RESULT_MAX)) cur_sat = rcm_pkg::RESULT_MAX;
		else                                          cur_sat = prod_q[rcm_pkg::RESULT_BITS-1:0];
	end

	// control-bearing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= rcm_pkg::SCALE_RESET;
			zero_q      <= ZERO_RST;
			count_q     <= '0;
			sum_q       <= '0;
			last_op_q   <= rcm_pkg::OP_MEASURE;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) scale_q <= cfg_data;

			valid_s1 <= cmd.accept && (count_q != COUNT_MAX);
			valid_s2 <= valid_s1;

			if (cmd.accept && window_last) last_op_q <= operation;

			if (cmd.finish) begin
				count_q <= '0;
				sum_q   <= '0;
				if (last_op_q == rcm_pkg::OP_CALIB) zero_q <= mean_sat;
			end else begin
				if (cmd.accept && count_q != COUNT_MAX) count_q <= count_q + 1'b1;
				if (valid_s2) begin
					if (sum_ext[SUM_BITS]) sum_q <= '1;
					else                   sum_q <= sum_ext[SUM_BITS-1:0];
				end
			end

			if (cmd.finish)                       out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)   out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1     <= operation;
			sample_s1 <= adc_sample;
		end

		if (op_s1 == rcm_pkg::OP_CALIB) add_s2 <= SQ_BITS'(sample_s1);
		else                            add_s2 <= square;

		if (cmd.div_load) begin
			num_q <= sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[SUM_BITS-2:0], q_bit};
			if (q_bit) rem_q <= trial_sub[COUNT_BITS-1:0];
			else       rem_q <= trial[COUNT_BITS-1:0];
		end

		if (cmd.sqrt_load) begin
			v_q    <= num_q;
			root_q <= '0;
			bit_q  <= BIT_TOP;
		end else if (cmd.sqrt_step) begin
			if (v_q >= root_try) begin
				v_q    <= v_q - root_try;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (cmd.scale) prod_q <= PROD_BITS'(root_q[ROOT_BITS-1:0]) * PROD_BITS'(scale_q);

		if (cmd.finish) begin
			if (last_op_q == rcm_pkg::OP_CALIB) begin
				out_kind_q  <= rcm_pkg::KIND_ZERO;
				out_value_q <= rcm_pkg::RESULT_BITS'(mean_sat);
			end else begin
				out_kind_q  <= rcm_pkg::KIND_CURRENT;
				out_value_q <= cur_sat;
			end
		end
	end

	assign sts.calib    = (last_op_q == rcm_pkg::OP_CALIB);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign result_kind  = out_kind_q;
	assign result_value = out_value_q;

endmodule

`default_nettype wire
